FILE: rtl/ycc420_pkg.sv
// Shared types and conversion constants for the 4:2:0 quad to RGBA converter.
`timescale 1ns / 1ps

package ycc420_pkg;

    localparam int SAMPLE_W = 8;
    localparam int OFFSET_W = 10;
    localparam int PIXEL_W  = 32;
    localparam int PROD_W   = 16;

    // Full-range BT.601 coefficients in 1/256 units, and the matching biases.
    localparam int CR_RED_COEF   = 103;
    localparam int RED_BIAS      = 179;
    localparam int CB_GREEN_COEF = 88;
    localparam int CB_GREEN_BIAS = 44;
    localparam int CR_GREEN_COEF = 183;
    localparam int CR_GREEN_BIAS = 91;
    localparam int CB_BLUE_COEF  = 198;
    localparam int BLUE_BIAS     = 227;

    localparam logic [SAMPLE_W-1:0] CHANNEL_MAX = 8'hff;
    localparam logic [SAMPLE_W-1:0] ALPHA_BYTE  = 8'hff;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [PIXEL_W-1:0]  pixel_t;

    // Chroma offsets shared by the four pixels of a block, two's complement.
    typedef struct packed {
        logic signed [OFFSET_W-1:0] red;
        logic signed [OFFSET_W-1:0] green;
        logic signed [OFFSET_W-1:0] blue;
    } offsets_t;

endpackage

FILE: rtl/ycbcr420_quad_to_rgba.sv
// Top level: converts one 2x2 block of 4:2:0 YCbCr samples to four RGBA pixels.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    luma_top_left .. luma_bottom_right, chroma_blue,
//                                    chroma_red (8 bits each)
//   output    out_valid / out_ready  pixel_top_left .. pixel_bottom_right (32 bits each)
//
// A request is registered at the input, converted by constant multiplies, adds
// and clamps, and moves into the output register once that register is empty
// or being emptied; one block per cycle moves through when the output is taken
// each cycle.
// The input register refills whenever it moves on to the output register, so
// a new request is taken while a finished result still waits downstream.
// Reset clears both valid flags; the data registers are not reset.
// With out_ready low the result holds, and at most one more request is taken.
`timescale 1ns / 1ps

module ycbcr420_quad_to_rgba
    import ycc420_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t luma_top_left,
    input  sample_t luma_top_right,
    input  sample_t luma_bottom_left,
    input  sample_t luma_bottom_right,
    input  sample_t chroma_blue,
    input  sample_t chroma_red,
    output logic    out_valid,
    input  logic    out_ready,
    output pixel_t  pixel_top_left,
    output pixel_t  pixel_top_right,
    output pixel_t  pixel_bottom_left,
    output pixel_t  pixel_bottom_right
);

    // Input stage registers.
    logic    in_valid_reg;
    logic    in_valid_next;
    sample_t luma_tl_reg;
    sample_t luma_tr_reg;
    sample_t luma_bl_reg;
    sample_t luma_br_reg;
    sample_t chroma_blue_reg;
    sample_t chroma_red_reg;

    // Result stage registers.
    logic    out_valid_reg;
    logic    out_valid_next;
    pixel_t  pixel_tl_reg;
    pixel_t  pixel_tr_reg;
    pixel_t  pixel_bl_reg;
    pixel_t  pixel_br_reg;

    logic     in_take;
    logic     stage_move;
    offsets_t offsets;
    pixel_t   pixel_tl;
    pixel_t   pixel_tr;
    pixel_t   pixel_bl;
    pixel_t   pixel_br;

    // The input stage hands over when the result register is empty or is
    // being emptied in this cycle.
    assign stage_move = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || stage_move;
    assign in_take    = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (stage_move)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stage_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            luma_tl_reg     <= luma_top_left;
            luma_tr_reg     <= luma_top_right;
            luma_bl_reg     <= luma_bottom_left;
            luma_br_reg     <= luma_bottom_right;
            chroma_blue_reg <= chroma_blue;
            chroma_red_reg  <= chroma_red;
        end
    end

    // The offsets depend only on the shared chroma pair and feed all four pixels.
    ycc420_chroma_offsets u_offsets (
        .chroma_blue (chroma_blue_reg),
        .chroma_red  (chroma_red_reg),
        .offsets     (offsets)
    );

    ycc420_pixel_pack u_pack_tl (
        .luma    (luma_tl_reg),
        .offsets (offsets),
        .pixel   (pixel_tl)
    );

    ycc420_pixel_pack u_pack_tr (
        .luma    (luma_tr_reg),
        .offsets (offsets),
        .pixel   (pixel_tr)
    );

    ycc420_pixel_pack u_pack_bl (
        .luma    (luma_bl_reg),
        .offsets (offsets),
        .pixel   (pixel_bl)
    );

    ycc420_pixel_pack u_pack_br (
        .luma    (luma_br_reg),
        .offsets (offsets),
        .pixel   (pixel_br)
    );

    always_ff @(posedge clk)
    begin
        if (stage_move)
        begin
            pixel_tl_reg <= pixel_tl;
            pixel_tr_reg <= pixel_tr;
            pixel_bl_reg <= pixel_bl;
            pixel_br_reg <= pixel_br;
        end
    end

    assign out_valid          = out_valid_reg;
    assign pixel_top_left     = pixel_tl_reg;
    assign pixel_top_right    = pixel_tr_reg;
    assign pixel_bottom_left  = pixel_bl_reg;
    assign pixel_bottom_right = pixel_br_reg;

endmodule

FILE: rtl/ycc420_chroma_offsets.sv
// Forms the red, green and blue offsets from the shared Cb and Cr samples.
`timescale 1ns / 1ps

module ycc420_chroma_offsets
    import ycc420_pkg::*;
(
    input  sample_t  chroma_blue,
    input  sample_t  chroma_red,
    output offsets_t offsets
);

    logic [PROD_W-1:0]   cr_red_prod;
    logic [PROD_W-1:0]   cb_green_prod;
    logic [PROD_W-1:0]   cr_green_prod;
    logic [PROD_W-1:0]   cb_blue_prod;
    logic [OFFSET_W-1:0] cb_ext;
    logic [OFFSET_W-1:0] cr_ext;

    assign cb_ext = {2'b00, chroma_blue};
    assign cr_ext = {2'b00, chroma_red};

    assign cr_red_prod   = PROD_W'(chroma_red)  * PROD_W'(CR_RED_COEF);
    assign cb_green_prod = PROD_W'(chroma_blue) * PROD_W'(CB_GREEN_COEF);
    assign cr_green_prod = PROD_W'(chroma_red)  * PROD_W'(CR_GREEN_COEF);
    assign cb_blue_prod  = PROD_W'(chroma_blue) * PROD_W'(CB_BLUE_COEF);

    // Every offset fits in ten bits, so wrapping arithmetic gives the exact
    // two's complement value.
    always_comb
    begin
        offsets.red   = $signed(cr_ext + {2'b00, cr_red_prod[PROD_W-1:8]}
                        - OFFSET_W'(RED_BIAS));
        offsets.green = $signed({2'b00, cb_green_prod[PROD_W-1:8]}
                        - OFFSET_W'(CB_GREEN_BIAS)
                        + {2'b00, cr_green_prod[PROD_W-1:8]}
                        - OFFSET_W'(CR_GREEN_BIAS));
        offsets.blue  = $signed(cb_ext + {2'b00, cb_blue_prod[PROD_W-1:8]}
                        - OFFSET_W'(BLUE_BIAS));
    end

endmodule

FILE: rtl/ycc420_pixel_pack.sv
// Luma plus red/blue offsets, minus green offset, saturated and packed as RGBA.
`timescale 1ns / 1ps

module ycc420_pixel_pack
    import ycc420_pkg::*;
(
    input  sample_t  luma,
    input  offsets_t offsets,
    output pixel_t   pixel
);

    logic signed [OFFSET_W:0] red_sum;
    logic signed [OFFSET_W:0] green_sum;
    logic signed [OFFSET_W:0] blue_sum;
    logic signed [OFFSET_W:0] luma_ext;
    sample_t                  red;
    sample_t                  green;
    sample_t                  blue;

    function automatic sample_t saturate(input logic signed [OFFSET_W:0] value);
        sample_t result;
        if (value[OFFSET_W])
        begin
            result = '0;
        end
        else if (value[OFFSET_W-1:SAMPLE_W] != '0)
        begin
            result = CHANNEL_MAX;
        end
        else
        begin
            result = value[SAMPLE_W-1:0];
        end
        return result;
    endfunction

    assign luma_ext  = $signed({3'b000, luma});
    assign red_sum   = luma_ext + $signed({offsets.red[OFFSET_W-1], offsets.red});
    assign green_sum = luma_ext - $signed({offsets.green[OFFSET_W-1], offsets.green});
    assign blue_sum  = luma_ext + $signed({offsets.blue[OFFSET_W-1], offsets.blue});

    assign red   = saturate(red_sum);
    assign green = saturate(green_sum);
    assign blue  = saturate(blue_sum);

    assign pixel = {ALPHA_BYTE, blue, green, red};

endmodule

FILE: rtl/ycc420_checker.sv
// Port-level checks for the quad converter, bound to its top level.
`timescale 1ns / 1ps

module ycc420_checker
    import ycc420_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input sample_t luma_top_left,
    input sample_t luma_top_right,
    input sample_t luma_bottom_left,
    input sample_t luma_bottom_right,
    input sample_t chroma_blue,
    input sample_t chroma_red,
    input logic    out_valid,
    input logic    out_ready,
    input pixel_t  pixel_top_left,
    input pixel_t  pixel_top_right,
    input pixel_t  pixel_bottom_left,
    input pixel_t  pixel_bottom_right
);

    // A stalled result stays valid, and its top-left and bottom-right pixels hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_top_left)
            && $stable(pixel_bottom_right))
        else $error("stalled result changed or dropped");

    // A waiting request keeps its samples until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(luma_top_left)
            && $stable(luma_top_right) && $stable(luma_bottom_left)
            && $stable(luma_bottom_right) && $stable(chroma_blue)
            && $stable(chroma_red))
        else $error("waiting request changed or dropped");

    // With the result register empty, the input stage can always move on.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while output is empty");

    // A fresh result follows an accepted request via the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching request");

    // Alpha is opaque on every pixel of every result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pixel_top_left[31:24] == ALPHA_BYTE
            && pixel_top_right[31:24] == ALPHA_BYTE
            && pixel_bottom_left[31:24] == ALPHA_BYTE
            && pixel_bottom_right[31:24] == ALPHA_BYTE)
        else $error("alpha byte not opaque");

endmodule

bind ycbcr420_quad_to_rgba ycc420_checker u_checker (.*);
